// ===== design/sdinit_pkg.sv =====
// sdinit_pkg: types and constants for the sd card bring-up sequencer
// phase encoding, command indexes, result codes and fixed command arguments
// no dependencies
package sdinit_pkg;

    // sizing defaults
    localparam int TIMER_BITS_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // action codes on the input channel
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DONE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // response kinds
    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_SHORT = 2'd1;
    localparam logic [1:0] RK_NOCRC = 2'd2;
    localparam logic [1:0] RK_LONG  = 2'd3;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID  = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA      = 6'd3;
    localparam logic [5:0] ACMD_SET_BUS_WID  = 6'd6;
    localparam logic [5:0] CMD_SELECT        = 6'd7;
    localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
    localparam logic [5:0] CMD_SEND_STATUS   = 6'd13;
    localparam logic [5:0] ACMD_SD_OP_COND   = 6'd41;
    localparam logic [5:0] CMD_APP           = 6'd55;

    // fixed arguments and expected response fields
    localparam logic [31:0] VOLT_ECHO_ARG  = 32'h0000_01AA;
    localparam logic [11:0] VOLT_ECHO      = 12'h1AA;
    localparam logic [31:0] ACMD41_ARG     = 32'h40FF_8000;
    localparam logic [31:0] BUS_WIDTH_ARG  = 32'h0000_0002;
    localparam logic [3:0]  TRAN_STATE     = 4'h4;

    // result codes
    localparam logic [3:0] RC_OK          = 4'd0;
    localparam logic [3:0] RC_NO_CARD     = 4'd1;
    localparam logic [3:0] RC_RESET       = 4'd2;
    localparam logic [3:0] RC_VOLTAGE     = 4'd3;
    localparam logic [3:0] RC_HANDSHAKE   = 4'd4;
    localparam logic [3:0] RC_NOT_HC      = 4'd5;
    localparam logic [3:0] RC_CID         = 4'd6;
    localparam logic [3:0] RC_RCA         = 4'd7;
    localparam logic [3:0] RC_CSD         = 4'd8;
    localparam logic [3:0] RC_SELECT      = 4'd9;
    localparam logic [3:0] RC_BUS_WIDTH   = 4'd10;
    localparam logic [3:0] RC_SPEED       = 4'd11;

    // sequencer phase: which command is outstanding
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_CMD55  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD2   = 4'd5,
        PH_CMD3   = 4'd6,
        PH_CMD9   = 4'd7,
        PH_CMD7   = 4'd8,
        PH_SEL13  = 4'd9,
        PH_ACMD6  = 4'd10,
        PH_CONF13 = 4'd11
    } phase_t;

endpackage

// ===== design/sd_card_init_sequencer_top.sv =====
// sd_card_init_sequencer_top: host-side bring-up sequencer for high-capacity sd cards
// input register, combinational decision logic, result register
// depends on sdinit_pkg
//
// usage
//   input channel (in_valid/in_stall) carries one event per transfer: start,
//   command completed (status plus response words) or a one millisecond tick
//   output channel (out_valid/out_stall) carries at most one result per event:
//   either the next command to send or the end of the sequence with a code
//   card_address, sector_total and product_name travel with every result
//   cfg channel (cfg_valid/cfg_ready) writes the acmd41 handshake timeout in
//   milliseconds; cfg_ready is always high, write only while idle
// timing
//   an event is decided while it sits in the input register and its result
//   goes to the result register, so out_valid follows both registers; one event
//   per cycle sustained unless out_stall holds, set by the single decision stage
// reset
//   rst_n clears phase to idle, the timer and the captured card data to zero
//   and the timeout to 1000 ms
// stall
//   a stalled result holds; the decision stage waits while the result register
//   is full and stalled, and in_stall rises only when the input register also
//   holds a waiting event
module sd_card_init_sequencer_top #(
    parameter int TIMER_BITS = sdinit_pkg::TIMER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    // event input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic        card_present,
    input  logic        cmd_ok,
    input  logic [31:0] resp_word0,
    input  logic [31:0] resp_word1,
    input  logic [31:0] resp_word2,
    input  logic [31:0] resp_word3,

    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        issue_cmd,
    output logic [5:0]  cmd_index,
    output logic [31:0] cmd_arg,
    output logic [1:0]  resp_kind,
    output logic        fast_clock,
    output logic        done_res,
    output logic [3:0]  result_code,
    output logic [15:0] card_address,
    output logic [32:0] sector_total,
    output logic [39:0] product_name
);

    // width used to compare the timer with the 16-bit timeout
    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // input register
    logic        in_valid_reg;
    logic [1:0]  action_reg;
    logic        present_reg;
    logic        ok_reg;
    logic [31:0] w0_reg;
    logic [31:0] w1_reg;
    logic [31:0] w2_reg;

    // sequencer state
    sdinit_pkg::phase_t    phase_reg, phase_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [15:0]           timeout_reg;
    logic [15:0]           rca_reg, rca_next;
    logic [32:0]           sector_reg, sector_next;
    logic [39:0]           name_reg, name_next;

    // result register
    logic        out_valid_reg;
    logic        issue_reg;
    logic [5:0]  index_reg;
    logic [31:0] arg_reg;
    logic [1:0]  kind_reg;
    logic        fast_reg;
    logic        done_reg;
    logic [3:0]  code_reg;
    logic [15:0] addr_reg;
    logic [32:0] total_reg;
    logic [39:0] pname_reg;

    // decision outputs
    logic        res_fire;
    logic        res_issue;
    logic [5:0]  res_index;
    logic [31:0] res_arg;
    logic [1:0]  res_kind;
    logic        res_fast;
    logic        res_done;
    logic [3:0]  res_code;

    // shared conditions
    logic             process;
    logic             in_take;
    logic [CMP_W-1:0] elapsed_ext;
    logic [CMP_W-1:0] timeout_ext;
    logic             timed_out;
    logic             zero_timeout;
    logic             echo_ok;
    logic             tran_ok;
    logic             ready_bit;
    logic             hc_bit;
    logic [31:0]      addr_arg;
    logic [31:0]      new_addr_arg;
    logic [21:0]      c_size;

    // the decision stage runs when the result register is free or draining
    assign process  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    assign elapsed_ext  = CMP_W'(elapsed_reg);
    assign timeout_ext  = CMP_W'(timeout_reg);
    assign timed_out    = elapsed_ext >= timeout_ext;
    // after cmd8 passes the timer is cleared, so only a zero timeout fails
    assign zero_timeout = (timeout_reg == 16'd0);
    assign echo_ok      = ok_reg && (w0_reg[11:0] == sdinit_pkg::VOLT_ECHO);
    assign tran_ok      = ok_reg && (w0_reg[12:9] == sdinit_pkg::TRAN_STATE);
    assign ready_bit    = w0_reg[31];
    assign hc_bit       = w0_reg[30];
    assign addr_arg     = {rca_reg, 16'h0000};
    assign new_addr_arg = {w0_reg[31:16], 16'h0000};
    // c_size sits at csd bits 69..48
    assign c_size       = {w1_reg[5:0], w2_reg[31:16]};

    // input register: word3 carries only csd/cid low bits, none of which are used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg  <= action;
            present_reg <= card_present;
            ok_reg      <= cmd_ok;
            w0_reg      <= resp_word0;
            w1_reg      <= resp_word1;
            w2_reg      <= resp_word2;
        end
    end

    // next state and captured card data
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        rca_next     = rca_reg;
        sector_next  = sector_reg;
        name_next    = name_reg;
        priority if (action_reg == sdinit_pkg::ACT_TICK)
        begin
            if (elapsed_reg != {TIMER_BITS{1'b1}})
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end
        else if (action_reg == sdinit_pkg::ACT_START)
        begin
            phase_next = present_reg ? sdinit_pkg::PH_CMD0 : sdinit_pkg::PH_IDLE;
        end
        else if (action_reg == sdinit_pkg::ACT_DONE)
        begin
            unique case (phase_reg)
                sdinit_pkg::PH_IDLE:
                begin
                    phase_next = sdinit_pkg::PH_IDLE;
                end
                sdinit_pkg::PH_CMD0:
                begin
                    phase_next = ok_reg ? sdinit_pkg::PH_CMD8 : sdinit_pkg::PH_IDLE;
                end
                sdinit_pkg::PH_CMD8:
                begin
                    if (echo_ok)
                    begin
                        elapsed_next = '0;
                        phase_next   = zero_timeout ? sdinit_pkg::PH_IDLE
                                                    : sdinit_pkg::PH_CMD55;
                    end
                    else
                    begin
                        phase_next = sdinit_pkg::PH_IDLE;
                    end
                end
                sdinit_pkg::PH_CMD55:
                begin
                    phase_next = ok_reg ? sdinit_pkg::PH_ACMD41 : sdinit_pkg::PH_IDLE;
                end
                sdinit_pkg::PH_ACMD41:
                begin
                    priority if (!ok_reg)
                        phase_next = sdinit_pkg::PH_IDLE;
                    else if (!ready_bit)
                        phase_next = timed_out ? sdinit_pkg::PH_IDLE
                                               : sdinit_pkg::PH_CMD55;
                    else if (!hc_bit)
                        phase_next = sdinit_pkg::PH_IDLE;
                    else
                        phase_next = sdinit_pkg::PH_CMD2;
                end
                sdinit_pkg::PH_CMD2:
                begin
                    if (ok_reg)
                    begin
                        name_next  = {w0_reg[7:0], w1_reg};
                        phase_next = sdinit_pkg::PH_CMD3;
                    end
                    else
                    begin
                        phase_next = sdinit_pkg::PH_IDLE;
                    end
                end
                sdinit_pkg::PH_CMD3:
                begin
                    if (ok_reg)
                    begin
                        rca_next   = w0_reg[31:16];
                        phase_next = sdinit_pkg::PH_CMD9;
                    end
                    else
                    begin
                        phase_next = sdinit_pkg::PH_IDLE;
                    end
                end
                sdinit_pkg::PH_CMD9:
                begin
                    if (ok_reg)
                    begin
                        // (c_size + 1) * 1024
                        sector_next = {(23'(c_size) + 23'd1), 10'd0};
                        phase_next  = sdinit_pkg::PH_CMD7;
                    end
                    else
                    begin
                        phase_next = sdinit_pkg::PH_IDLE;
                    end
                end
                sdinit_pkg::PH_CMD7:
                begin
                    phase_next = ok_reg ? sdinit_pkg::PH_SEL13 : sdinit_pkg::PH_IDLE;
                end
                sdinit_pkg::PH_SEL13:
                begin
                    phase_next = tran_ok ? sdinit_pkg::PH_ACMD6 : sdinit_pkg::PH_IDLE;
                end
                sdinit_pkg::PH_ACMD6:
                begin
                    phase_next = ok_reg ? sdinit_pkg::PH_CONF13 : sdinit_pkg::PH_IDLE;
                end
                sdinit_pkg::PH_CONF13:
                begin
                    phase_next = sdinit_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

    // result for the event in the decision stage
    always_comb
    begin
        res_fire  = 1'b0;
        res_issue = 1'b0;
        res_index = sdinit_pkg::CMD_GO_IDLE;
        res_arg   = '0;
        res_kind  = sdinit_pkg::RK_NONE;
        res_fast  = 1'b0;
        res_done  = 1'b0;
        res_code  = sdinit_pkg::RC_OK;
        priority if (action_reg == sdinit_pkg::ACT_START)
        begin
            res_fire = 1'b1;
            if (present_reg)
            begin
                res_issue = 1'b1;
                res_index = sdinit_pkg::CMD_GO_IDLE;
                res_kind  = sdinit_pkg::RK_NONE;
            end
            else
            begin
                res_done = 1'b1;
                res_code = sdinit_pkg::RC_NO_CARD;
            end
        end
        else if (action_reg == sdinit_pkg::ACT_DONE)
        begin
            res_fire = (phase_reg != sdinit_pkg::PH_IDLE);
            unique case (phase_reg)
                sdinit_pkg::PH_IDLE:
                begin
                    res_fire = 1'b0;
                end
                sdinit_pkg::PH_CMD0:
                begin
                    if (ok_reg)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_SEND_IF_COND;
                        res_arg   = sdinit_pkg::VOLT_ECHO_ARG;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_RESET;
                    end
                end
                sdinit_pkg::PH_CMD8:
                begin
                    priority if (!echo_ok)
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_VOLTAGE;
                    end
                    else if (zero_timeout)
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_HANDSHAKE;
                    end
                    else
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_APP;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                end
                sdinit_pkg::PH_CMD55:
                begin
                    if (ok_reg)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::ACMD_SD_OP_COND;
                        res_arg   = sdinit_pkg::ACMD41_ARG;
                        res_kind  = sdinit_pkg::RK_NOCRC;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_HANDSHAKE;
                    end
                end
                sdinit_pkg::PH_ACMD41:
                begin
                    priority if (!ok_reg || (!ready_bit && timed_out))
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_HANDSHAKE;
                    end
                    else if (!ready_bit)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_APP;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                    else if (!hc_bit)
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_NOT_HC;
                    end
                    else
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_ALL_SEND_CID;
                        res_kind  = sdinit_pkg::RK_LONG;
                    end
                end
                sdinit_pkg::PH_CMD2:
                begin
                    if (ok_reg)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_SEND_RCA;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_CID;
                    end
                end
                sdinit_pkg::PH_CMD3:
                begin
                    if (ok_reg)
                    begin
                        // cmd9 is addressed with the rca just received
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_SEND_CSD;
                        res_arg   = new_addr_arg;
                        res_kind  = sdinit_pkg::RK_LONG;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_RCA;
                    end
                end
                sdinit_pkg::PH_CMD9:
                begin
                    if (ok_reg)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_SELECT;
                        res_arg   = addr_arg;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_CSD;
                    end
                end
                sdinit_pkg::PH_CMD7:
                begin
                    if (ok_reg)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_SEND_STATUS;
                        res_arg   = addr_arg;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_SELECT;
                    end
                end
                sdinit_pkg::PH_SEL13:
                begin
                    if (tran_ok)
                    begin
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::ACMD_SET_BUS_WID;
                        res_arg   = sdinit_pkg::BUS_WIDTH_ARG;
                        res_kind  = sdinit_pkg::RK_SHORT;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_SELECT;
                    end
                end
                sdinit_pkg::PH_ACMD6:
                begin
                    if (ok_reg)
                    begin
                        // fast clock goes out together with the confirming status read
                        res_issue = 1'b1;
                        res_index = sdinit_pkg::CMD_SEND_STATUS;
                        res_arg   = addr_arg;
                        res_kind  = sdinit_pkg::RK_SHORT;
                        res_fast  = 1'b1;
                    end
                    else
                    begin
                        res_done = 1'b1;
                        res_code = sdinit_pkg::RC_BUS_WIDTH;
                    end
                end
                sdinit_pkg::PH_CONF13:
                begin
                    res_done = 1'b1;
                    res_code = tran_ok ? sdinit_pkg::RC_OK : sdinit_pkg::RC_SPEED;
                end
                default:
                begin
                    res_fire = 1'b0;
                end
            endcase
        end
        else
        begin
            // ticks and unused action codes give no result
            res_fire = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sdinit_pkg::PH_IDLE;
            elapsed_reg <= '0;
            rca_reg     <= '0;
            sector_reg  <= '0;
            name_reg    <= '0;
            timeout_reg <= sdinit_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (process)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                rca_reg     <= rca_next;
                sector_reg  <= sector_next;
                name_reg    <= name_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && res_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && res_fire)
        begin
            issue_reg <= res_issue;
            index_reg <= res_index;
            arg_reg   <= res_arg;
            kind_reg  <= res_kind;
            fast_reg  <= res_fast;
            done_reg  <= res_done;
            code_reg  <= res_code;
            addr_reg  <= rca_next;
            total_reg <= sector_next;
            pname_reg <= name_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign issue_cmd    = issue_reg;
    assign cmd_index    = index_reg;
    assign cmd_arg      = arg_reg;
    assign resp_kind    = kind_reg;
    assign fast_clock   = fast_reg;
    assign done_res     = done_reg;
    assign result_code  = code_reg;
    assign card_address = addr_reg;
    assign sector_total = total_reg;
    assign product_name = pname_reg;

endmodule

// ===== test/sd_card_init_sequencer_checker.sv =====
// sdinit_checker: watches the cfg, event and result channels of the sd init sequencer,
// predicts every result on its own copy of the sequencer state and compares field by field
// depends on sdinit_pkg
module sdinit_checker
    import sdinit_pkg::*;
#(
    parameter int TIMER_BITS = sdinit_pkg::TIMER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic        card_present,
    input  logic        cmd_ok,
    input  logic [31:0] resp_word0,
    input  logic [31:0] resp_word1,
    input  logic [31:0] resp_word2,
    input  logic [31:0] resp_word3,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        issue_cmd,
    input  logic [5:0]  cmd_index,
    input  logic [31:0] cmd_arg,
    input  logic [1:0]  resp_kind,
    input  logic        fast_clock,
    input  logic        done_res,
    input  logic [3:0]  result_code,
    input  logic [15:0] card_address,
    input  logic [32:0] sector_total,
    input  logic [39:0] product_name,
    output int          mismatches,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic        issue;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [1:0]  kind;
        logic        fast;
        logic        done;
        logic [3:0]  code;
        logic [15:0] rca;
        logic [32:0] sectors;
        logic [39:0] pname;
    } seq_out_t;

    localparam logic [TIMER_BITS-1:0] MS_MAX = {TIMER_BITS{1'b1}};

    // shadow of the sequencer state
    phase_t                seq_phase;
    logic [TIMER_BITS-1:0] ms_count;
    logic [15:0]           timeout_q;
    logic [15:0]           rca_q;
    logic [32:0]           sectors_q;
    logic [39:0]           pname_q;

    seq_out_t awaited[$];
    int err_n;
    int checked_n;

    function automatic seq_out_t issue(input logic [5:0] cmd, input logic [31:0] arg,
                                       input logic [1:0] kind, input logic fast,
                                       input phase_t next);
        seq_out_t r;
        r = '0;
        r.issue = 1'b1;
        r.cmd = cmd;
        r.arg = arg;
        r.kind = kind;
        r.fast = fast;
        r.rca = rca_q;
        r.sectors = sectors_q;
        r.pname = pname_q;
        seq_phase = next;
        return r;
    endfunction

    function automatic seq_out_t finish(input logic [3:0] code);
        seq_out_t r;
        r = '0;
        r.done = 1'b1;
        r.code = code;
        r.rca = rca_q;
        r.sectors = sectors_q;
        r.pname = pname_q;
        seq_phase = PH_IDLE;
        return r;
    endfunction

    // timeout is checked before every app command
    function automatic seq_out_t app_cmd();
        if (ms_count >= timeout_q)
            return finish(RC_HANDSHAKE);
        return issue(CMD_APP, 32'h0, RK_SHORT, 1'b0, PH_CMD55);
    endfunction

    function automatic bit next_seq_out(input logic [1:0] act, input logic present,
                                        input logic ok, input logic [31:0] w0,
                                        input logic [31:0] w1, input logic [31:0] w2,
                                        output seq_out_t r);
        logic [31:0] sel_arg;
        sel_arg = {rca_q, 16'h0000};
        r = '0;
        case (act)
            ACT_TICK:
            begin
                if (ms_count != MS_MAX)
                    ms_count = ms_count + 1'b1;
                return 1'b0;
            end
            ACT_START:
            begin
                if (present)
                    r = issue(CMD_GO_IDLE, 32'h0, RK_NONE, 1'b0, PH_CMD0);
                else
                    r = finish(RC_NO_CARD);
                return 1'b1;
            end
            ACT_DONE:
                ;
            default:
                return 1'b0;
        endcase
        case (seq_phase)
            PH_CMD0:
                r = ok ? issue(CMD_SEND_IF_COND, VOLT_ECHO_ARG, RK_SHORT, 1'b0, PH_CMD8)
                       : finish(RC_RESET);
            PH_CMD8:
            begin
                if (!ok || w0[11:0] != VOLT_ECHO)
                    r = finish(RC_VOLTAGE);
                else
                begin
                    ms_count = '0;
                    r = app_cmd();
                end
            end
            PH_CMD55:
                r = ok ? issue(ACMD_SD_OP_COND, ACMD41_ARG, RK_NOCRC, 1'b0, PH_ACMD41)
                       : finish(RC_HANDSHAKE);
            PH_ACMD41:
            begin
                // bit 31 ready, bit 30 high capacity
                if (!ok)
                    r = finish(RC_HANDSHAKE);
                else if (!w0[31])
                    r = app_cmd();
                else if (!w0[30])
                    r = finish(RC_NOT_HC);
                else
                    r = issue(CMD_ALL_SEND_CID, 32'h0, RK_LONG, 1'b0, PH_CMD2);
            end
            PH_CMD2:
            begin
                if (!ok)
                    r = finish(RC_CID);
                else
                begin
                    pname_q = {w0[7:0], w1};
                    r = issue(CMD_SEND_RCA, 32'h0, RK_SHORT, 1'b0, PH_CMD3);
                end
            end
            PH_CMD3:
            begin
                if (!ok)
                    r = finish(RC_RCA);
                else
                begin
                    rca_q = w0[31:16];
                    r = issue(CMD_SEND_CSD, {rca_q, 16'h0000}, RK_LONG, 1'b0, PH_CMD9);
                end
            end
            PH_CMD9:
            begin
                if (!ok)
                    r = finish(RC_CSD);
                else
                begin
                    // c_size sits in csd bits 69..48
                    sectors_q = ({11'd0, w1[5:0], w2[31:16]} + 33'd1) << 10;
                    r = issue(CMD_SELECT, sel_arg, RK_SHORT, 1'b0, PH_CMD7);
                end
            end
            PH_CMD7:
                r = ok ? issue(CMD_SEND_STATUS, sel_arg, RK_SHORT, 1'b0, PH_SEL13)
                       : finish(RC_SELECT);
            PH_SEL13:
                r = (ok && w0[12:9] == TRAN_STATE)
                    ? issue(ACMD_SET_BUS_WID, BUS_WIDTH_ARG, RK_SHORT, 1'b0, PH_ACMD6)
                    : finish(RC_SELECT);
            PH_ACMD6:
                r = ok ? issue(CMD_SEND_STATUS, sel_arg, RK_SHORT, 1'b1, PH_CONF13)
                       : finish(RC_BUS_WIDTH);
            PH_CONF13:
                r = (ok && w0[12:9] == TRAN_STATE) ? finish(RC_OK) : finish(RC_SPEED);
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic string show(input seq_out_t r);
        return {$sformatf("issue=%0b cmd=%0d arg=%h kind=%0d fast=%0b",
                          r.issue, r.cmd, r.arg, r.kind, r.fast),
                $sformatf(" done=%0b code=%0d rca=%h sectors=%h name=%h",
                          r.done, r.code, r.rca, r.sectors, r.pname)};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        seq_out_t want;
        seq_out_t got;
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            ms_count = '0;
            timeout_q = TIMEOUT_RESET;
            rca_q = '0;
            sectors_q = '0;
            pname_q = '0;
            awaited.delete();
            err_n = 0;
            checked_n = 0;
            mismatches <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                timeout_q = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (next_seq_out(action, card_present, cmd_ok, resp_word0, resp_word1,
                                 resp_word2, want))
                    awaited.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = {issue_cmd, cmd_index, cmd_arg, resp_kind, fast_clock, done_res,
                       result_code, card_address, sector_total, product_name};
                if (awaited.size() == 0)
                begin
                    err_n++;
                    if (err_n <= 10)
                        $display("unexpected result: %s", show(got));
                end
                else
                begin
                    want = awaited.pop_front();
                    checked_n++;
                    if (got !== want)
                    begin
                        err_n++;
                        if (err_n <= 10)
                        begin
                            $display("result %0d differs", checked_n);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
            mismatches <= err_n;
            pending <= awaited.size();
            checked <= checked_n;
        end
    end

endmodule

// ===== test/sd_card_init_sequencer_top_tb.sv =====
// sd_card_init_sequencer_top_tb: drives card bring-up events into the sequencer and
// gives the verdict; prediction and comparison live in sdinit_checker
// depends on sdinit_pkg, sd_card_init_sequencer_top and sdinit_checker
module sd_card_init_sequencer_top_tb;
    import sdinit_pkg::*;

    // action code the sequencer must ignore
    localparam logic [1:0]  ACT_NONE = 2'd3;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;
    // all ones except a card state of tran in bits 12..9 and a zero in bit 8
    localparam logic [31:0] TRAN_ONES = 32'hFFFF_E8FF;

    localparam int RANDOM_ITEMS  = 750;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    // longest legal quiet stretch is a sender wait plus the long hold, well below this
    localparam int IDLE_LIMIT    = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic        card_present;
    logic        cmd_ok;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        out_valid;
    logic        out_stall;
    logic        issue_cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic        fast_clock;
    logic        done_res;
    logic [3:0]  result_code;
    logic [15:0] card_address;
    logic [32:0] sector_total;
    logic [39:0] product_name;

    int mismatches;
    int pending;
    int checked;

    int n_events;
    int n_cfg;
    // receiver hold-off request, bumped by the sender and served by the receiver
    int hold_ask;
    logic holding;

    sd_card_init_sequencer_top DUT (.*);

    sdinit_checker u_check (.*);

    always #2 clk = ~clk;

    // one event transfer: payload and valid go up at a rising edge and stay until
    // the edge that accepts them; returns with valid still high unless a sender gap drops it
    task automatic send_event(input logic [1:0] act, input logic present, input logic ok,
                              input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2, input logic [31:0] w3);
        int r;
        int gap;
        action <= act;
        card_present <= present;
        cmd_ok <= ok;
        resp_word0 <= w0;
        resp_word1 <= w1;
        resp_word2 <= w2;
        resp_word3 <= w3;
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        if (act != ACT_NONE)
            n_events++;
        // sender gap: mostly none or short, now and then long
        r = $urandom_range(0, 99);
        if (r < 50)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic start_seq(input logic present);
        send_event(ACT_START, present, 1'($urandom_range(0, 1)), $urandom, $urandom,
                   $urandom, $urandom);
    endtask

    task automatic complete(input logic ok, input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2);
        send_event(ACT_DONE, 1'($urandom_range(0, 1)), ok, w0, w1, w2, $urandom);
    endtask

    task automatic tick();
        send_event(ACT_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                   $urandom, $urandom, $urandom);
    endtask

    // anything at all, including the ignored action code and out-of-order completions
    task automatic noise_event();
        send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
    endtask

    // a whole bring-up with random content; when faulty the sequence breaks at
    // fault_at (idle stands for a start with no card) and stops there
    task automatic bring_up(input logic faulty, input phase_t fault_at);
        logic [31:0] w;
        logic ok;
        phase_t p;
        if (faulty && fault_at == PH_IDLE)
        begin
            start_seq(1'b0);
            return;
        end
        start_seq(1'b1);
        ok = !(faulty && fault_at == PH_CMD0);
        complete(ok, $urandom, $urandom, $urandom);
        if (!ok)
            return;

        // voltage echo, upper bits random
        w = $urandom;
        w[11:0] = VOLT_ECHO;
        if (faulty && fault_at == PH_CMD8)
        begin
            if ($urandom_range(0, 1))
                complete(1'b0, w, $urandom, $urandom);
            else
            begin
                w[11:0] = 12'($urandom);
                if (w[11:0] == VOLT_ECHO)
                    w[0] = ~w[0];
                complete(1'b1, w, $urandom, $urandom);
            end
            return;
        end
        complete(1'b1, w, $urandom, $urandom);

        // busy rounds of the handshake loop, with ticks to run down the timeout
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) tick();
            complete(1'b1, $urandom, $urandom, $urandom);
            w = $urandom;
            w[31] = 1'b0;
            complete(1'b1, w, $urandom, $urandom);
        end
        if (faulty && fault_at == PH_CMD55)
        begin
            complete(1'b0, $urandom, $urandom, $urandom);
            return;
        end
        complete(1'b1, $urandom, $urandom, $urandom);
        w = $urandom;
        w[31] = 1'b1;
        w[30] = 1'b1;
        if (faulty && fault_at == PH_ACMD41)
        begin
            if ($urandom_range(0, 1))
                complete(1'b0, w, $urandom, $urandom);
            else
            begin
                // ready but standard capacity
                w[30] = 1'b0;
                complete(1'b1, w, $urandom, $urandom);
            end
            return;
        end
        complete(1'b1, w, $urandom, $urandom);

        // cid, rca, csd, select, status, bus width, confirming status
        p = PH_CMD2;
        repeat (7)
        begin
            ok = !(faulty && fault_at == p);
            w = $urandom;
            if (p == PH_SEL13 || p == PH_CONF13)
            begin
                if (ok)
                    w[12:9] = TRAN_STATE;
                else if ($urandom_range(0, 1))
                begin
                    // clean transfer, card in the wrong state
                    ok = 1'b1;
                    if (w[12:9] == TRAN_STATE)
                        w[9] = ~w[9];
                end
            end
            complete(ok, w, $urandom, $urandom);
            if (faulty && fault_at == p)
                return;
            p = p.next();
        end
    endtask

    // drain every expected result, then give in-flight ignored events time to clear
    task automatic settle_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] ms);
        cfg_data <= ms;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // receiver: random stall pattern, plus one long hold-off on request
    initial
    begin
        int r;
        int len;
        int seen;
        out_stall = 1'b0;
        holding = 1'b0;
        seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (seen != hold_ask)
            begin
                seen = hold_ask;
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 24);
                end
                else if (r < 93)
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 4);
                end
                else
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(20, 80);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // watchdog: too long without any transfer on any channel ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles, %0d results still awaited", IDLE_LIMIT, pending);
        $display("sd_card_init_sequencer_top: mismatch");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [15:0] timeout_plan [PHASES];
        int target;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_START;
        card_present = 1'b0;
        cmd_ok = 1'b0;
        resp_word0 = '0;
        resp_word1 = '0;
        resp_word2 = '0;
        resp_word3 = '0;
        n_events = 0;
        n_cfg = 0;
        hold_ask = 0;
        // timeout settings per random phase: small ones make the handshake loop
        // run out, zero fails at once, the top value never runs out
        timeout_plan[0] = 16'd3;
        timeout_plan[1] = 16'hFFFF;
        timeout_plan[2] = 16'd1;
        timeout_plan[3] = 16'd0;
        timeout_plan[4] = 16'($urandom_range(1, 65535));
        timeout_plan[5] = TIMEOUT_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset timeout of 1000 ms
        tick();                                   // tick while idle
        start_seq(1'b0);                          // no card inserted
        complete(1'b1, ONES, ONES, ONES);         // completion while idle is dropped
        send_event(ACT_NONE, 1'b1, 1'b1, ONES, ONES, ONES, ONES);

        // full bring-up with every response word as high as it may go;
        // c_size at its maximum gives a 33-bit sector count
        start_seq(1'b1);
        complete(1'b1, ONES, ONES, ONES);                 // cmd0
        complete(1'b1, 32'hFFFF_F1AA, ONES, ONES);        // cmd8 echo
        complete(1'b1, ONES, ONES, ONES);                 // cmd55
        complete(1'b1, 32'h7FFF_FFFF, ONES, ONES);        // acmd41 still busy
        complete(1'b1, ONES, ONES, ONES);                 // cmd55
        complete(1'b1, ONES, ONES, ONES);                 // acmd41 ready, high capacity
        complete(1'b1, ONES, ONES, ONES);                 // cmd2
        complete(1'b1, ONES, ONES, ONES);                 // cmd3, rca ffff
        complete(1'b1, ONES, ONES, ONES);                 // cmd9
        complete(1'b1, ONES, ONES, ONES);                 // cmd7
        complete(1'b1, TRAN_ONES, ONES, ONES);            // status in tran
        complete(1'b1, ONES, ONES, ONES);                 // acmd6
        complete(1'b1, TRAN_ONES, ONES, ONES);            // confirming status

        // reset command fails on an all-zero response
        start_seq(1'b1);
        complete(1'b0, 32'h0, 32'h0, 32'h0);

        // start while busy restarts, then the first app command fails
        start_seq(1'b1);
        complete(1'b1, 32'h0, 32'h0, 32'h0);
        start_seq(1'b1);
        complete(1'b1, 32'h0, 32'h0, 32'h0);
        complete(1'b1, 32'h0000_01AA, 32'h0, 32'h0);
        complete(1'b0, 32'h0, 32'h0, 32'h0);

        // random part, one timeout setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_idle();
            write_timeout(timeout_plan[ph]);
            if (ph == 0)
            begin
                // receiver holds off long while starts keep coming, so the block fills
                in_valid <= 1'b0;
                hold_ask <= hold_ask + 1;
                do
                    @(negedge clk);
                while (!holding);
                @(posedge clk);
                repeat (12) start_seq(1'b1);
            end
            target = n_events + RANDOM_ITEMS / PHASES;
            while (n_events < target)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    if ($urandom_range(0, 1))
                        bring_up(1'b0, PH_IDLE);
                    else
                        bring_up(1'b1, phase_t'($urandom_range(0, 11)));
                end
                else
                    noise_event();
            end
        end

        // drain, then a few more cycles for anything still in the pipeline
        settle_idle();
        repeat (8) @(posedge clk);
        @(negedge clk);
        $display("sent %0d events under %0d timeout settings, stalls and gaps on both sides",
                 n_events, n_cfg);
        $display("checked %0d results, %0d mismatches, %0d still awaited",
                 checked, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("sd_card_init_sequencer_top: match");
        else
            $display("sd_card_init_sequencer_top: mismatch");
        $finish;
    end

endmodule
